@@ rtl/cpm_pkg.sv @@
// Shared types and constants of the capture period meter.
// Used by cpm_ctrl, cpm_dp, cpm_outq and capture_period_meter_with_history.
package cpm_pkg;

  localparam int VAL_W   = 22;   // period and tolerance width
  localparam int OVF_W   = 6;    // overflow counter width
  localparam int CAP_W   = 16;   // captured timer count width
  localparam int IN_W    = 24;   // input tdata width
  localparam int OUT_W   = 48;   // output tdata width

  localparam logic [OVF_W-1:0] OVF_MAX     = 6'h3F;
  localparam logic [VAL_W-1:0] LIMIT_RESET = 22'd500;

  typedef enum logic [1:0] {
    CMD_TIMER  = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_NONE   = 2'd3
  } cpm_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SORT = 2'd1,
    ST_SCAN = 2'd2
  } cpm_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // input beat taken this cycle
    logic sort_en;     // one odd-even compare-swap phase
    logic sort_odd;    // phase works on odd pairs
    logic scan_en;     // rotate history by one and test the pair at its head
    logic scan_first;
    logic scan_last;
    logic push;        // write a result beat into the output queue
  } cpm_ctl_t;

endpackage

@@ rtl/capture_period_meter_with_history.sv @@
// Capture period meter with history. For a timer event, a poll or the unused code,
// the result beat is queued at the accepting edge, behind any beats still waiting.
// A select is accepted, then runs the odd-even sort phases and the rotation steps
// of the neighbor scan; its result beat is queued on the last scan step.
// A two-entry result queue keeps input accepted while results wait, until it is full.
// Reset (rst_ni low, asynchronous) clears status, history, limit to 500.
module capture_period_meter_with_history import cpm_pkg::*; #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] overflow_event, [1] edge_event, [17:2] captured_count, [23:18] zero
  input  logic [IN_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [0] restart_timer, [1] sample_ready, [23:2] period_value,
  // [45:24] selected_value, [47:46] zero
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [VAL_W-1:0] cfg_wdata_i
);

  cpm_ctl_t         ctl;
  cpm_cmd_e         cmd;
  logic             space;
  logic [OUT_W-1:0] result;

  assign cmd = cpm_cmd_e'(s_axis_tuser);

  cpm_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (cmd),
    .space_i    (space),
    .in_ready_o (s_axis_tready),
    .ctl_o      (ctl)
  );

  cpm_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .cmd_i            (cmd),
    .overflow_event_i (s_axis_tdata[0]),
    .edge_event_i     (s_axis_tdata[1]),
    .captured_count_i (s_axis_tdata[17:2]),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_o         (result)
  );

  cpm_outq u_outq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (ctl.push),
    .push_data_i     (result),
    .space_o         (space),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

@@ rtl/cpm_outq.sv @@
// Two-entry result queue between the datapath and the output stream.
// Depends on cpm_pkg for the result width.
module cpm_outq import cpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [OUT_W-1:0] push_data_i,
  output logic             space_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  logic [OUT_W-1:0] mem_q [2];
  logic [1:0]       count_q, count_d;
  logic             wr_ptr_q, rd_ptr_q;
  logic             pop;

  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tvalid_o = (count_q != 2'd0);
  assign m_axis_tdata_o  = mem_q[rd_ptr_q];
  assign space_o         = (count_q != 2'd2);

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |-> count_q != 2'd2)
    else $error("result pushed into a full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |=> count_q == $past(count_q) + 2'd1)
    else $error("queue count did not follow push");
`endif

endmodule

@@ rtl/cpm_ctrl.sv @@
// Controller of the capture period meter: accepts beats and sequences
// the sort and scan phases of a select. Depends on cpm_pkg.
module cpm_ctrl import cpm_pkg::*; #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  cpm_cmd_e in_cmd_i,
  input  logic     space_i,
  output logic     in_ready_o,
  output cpm_ctl_t ctl_o
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(HISTORY_DEPTH - 1);

  cpm_state_e       state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    ctl_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = space_i;
        accept     = in_valid_i && space_i;
        ctl_o.load = accept;
        if (accept) begin
          if (in_cmd_i == CMD_SELECT) begin
            state_d = ST_SORT;
            step_d  = '0;
          end else begin
            ctl_o.push = 1'b1;
          end
        end
      end
      ST_SORT: begin
        ctl_o.sort_en  = 1'b1;
        ctl_o.sort_odd = step_q[0];
        if (step_q == STEP_LAST) begin
          state_d = ST_SCAN;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_SCAN: begin
        ctl_o.scan_en    = 1'b1;
        ctl_o.scan_first = (step_q == '0);
        ctl_o.scan_last  = (step_q == STEP_LAST);
        if (step_q == STEP_LAST) begin
          // history is back in sorted order after a full rotation
          ctl_o.push = 1'b1;
          state_d    = ST_IDLE;
          step_d     = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

endmodule

@@ rtl/cpm_dp.sv @@
// Datapath of the capture period meter: measurement state, history ring,
// odd-even sort lanes and the rotating neighbor scan. Depends on cpm_pkg.
module cpm_dp import cpm_pkg::*; #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpm_ctl_t         ctl_i,
  input  cpm_cmd_e         cmd_i,
  input  logic             overflow_event_i,
  input  logic             edge_event_i,
  input  logic [CAP_W-1:0] captured_count_i,
  input  logic             cfg_we_i,
  input  logic [VAL_W-1:0] cfg_wdata_i,
  output logic [OUT_W-1:0] result_o
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

  logic [VAL_W-1:0]  limit_q;
  logic              done_q, done_d;
  logic              armed_q, armed_d;
  logic [OVF_W-1:0]  ovf_cnt_q, ovf_cnt_d;
  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [VAL_W-1:0]  hist_q [HISTORY_DEPTH];
  logic [VAL_W-1:0]  hist_d [HISTORY_DEPTH];
  logic [VAL_W-1:0]  last_q, last_d;
  logic              found_q, found_d;
  logic [VAL_W-1:0]  sel_q, sel_d;
  logic [VAL_W-1:0]  max_q, max_d;

  logic              restart, ready;
  logic [VAL_W-1:0]  selected, sample, gap;
  logic              found_cur, hit;
  logic [VAL_W-1:0]  max_cur;

  always_comb begin
    done_d    = done_q;
    armed_d   = armed_q;
    ovf_cnt_d = ovf_cnt_q;
    cap_d     = cap_q;
    slot_d    = slot_q;
    last_d    = last_q;
    hist_d    = hist_q;
    found_d   = found_q;
    sel_d     = sel_q;
    max_d     = max_q;
    restart   = 1'b0;
    ready     = 1'b0;
    selected  = '0;
    sample    = {ovf_cnt_q, cap_q};

    found_cur = ctl_i.scan_first ? 1'b0 : found_q;
    max_cur   = ctl_i.scan_first ? hist_q[HISTORY_DEPTH-1] : max_q;
    gap       = hist_q[1] - hist_q[0];
    hit       = !ctl_i.scan_last && !found_cur && (hist_q[0] != '0) && (gap < limit_q);

    if (ctl_i.load) begin
      case (cmd_i)
        CMD_TIMER: begin
          if (!done_q) begin
            if (overflow_event_i && armed_q) begin
              if (ovf_cnt_q == OVF_MAX) begin
                done_d = 1'b1;
                cap_d  = '0;
              end else begin
                ovf_cnt_d = ovf_cnt_q + 1'b1;
              end
            end
            if (edge_event_i) begin
              if (armed_q) begin
                cap_d  = captured_count_i;
                done_d = 1'b1;
              end else begin
                restart   = 1'b1;
                ovf_cnt_d = '0;
                cap_d     = '0;
                armed_d   = 1'b1;
              end
            end
          end
        end
        CMD_POLL: begin
          if (done_q) begin
            // advance the ring pointer before the write
            slot_d         = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
            hist_d[slot_d] = sample;
            last_d         = sample;
            done_d         = 1'b0;
            armed_d        = 1'b0;
            ovf_cnt_d      = '0;
            ready          = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (ctl_i.sort_en) begin
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
        if (((k % 2) == 1) == ctl_i.sort_odd && hist_q[k] > hist_q[k+1]) begin
          hist_d[k]   = hist_q[k+1];
          hist_d[k+1] = hist_q[k];
        end
      end
    end

    if (ctl_i.scan_en) begin
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
        hist_d[k] = hist_q[k+1];
      end
      hist_d[HISTORY_DEPTH-1] = hist_q[0];
      found_d = found_cur || hit;
      max_d   = max_cur;
      if (hit) begin
        sel_d = hist_q[0];
      end
      selected = found_cur ? sel_q : max_cur;
    end
  end

  // result beat: restart, ready, period, selected, pad
  assign result_o = {2'b00, selected, last_d, ready, restart};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RESET;
      done_q    <= 1'b0;
      armed_q   <= 1'b0;
      ovf_cnt_q <= '0;
      cap_q     <= '0;
      slot_q    <= '0;
      last_q    <= '0;
      found_q   <= 1'b0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      done_q    <= done_d;
      armed_q   <= armed_d;
      ovf_cnt_q <= ovf_cnt_d;
      cap_q     <= cap_d;
      slot_q    <= slot_d;
      last_q    <= last_d;
      found_q   <= found_d;
      hist_q    <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    max_q <= max_d;
  end

endmodule

@@ verif/capture_period_meter_with_history_chk.sv @@
// Checker for the capture period meter: follows the input and config ports, keeps its own
// meter state and history ring, and compares every output beat with the oldest prediction.
// Depends on cpm_pkg for widths and command codes.
module capture_period_meter_with_history_chk import cpm_pkg::*; #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic [1:0]       s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [VAL_W-1:0] cfg_wdata_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic             restart;
    logic             ready;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] selected;
  } meter_beat_t;

  logic [VAL_W-1:0] limit_q;
  logic             done_q;
  logic             armed_q;
  logic [OVF_W-1:0] ovf_cnt_q;
  logic [CAP_W-1:0] capture_q;
  int unsigned      slot_q;
  logic [VAL_W-1:0] history_q [HISTORY_DEPTH];
  logic [VAL_W-1:0] last_period_q;

  meter_beat_t meter_results_q [$];
  int          fail_cnt = 0;

  assign errors_o = fail_cnt;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  // Sort the ring in place, then take the first nonzero entry with a close upper neighbor, else the largest.
  function automatic logic [VAL_W-1:0] pick_steady_period();
    logic [VAL_W-1:0] tmp;
    for (int p = 0; p < HISTORY_DEPTH - 1; p++) begin
      for (int k = 0; k + 1 + p < HISTORY_DEPTH; k++) begin
        if (history_q[k] > history_q[k+1]) begin
          tmp = history_q[k];
          history_q[k] = history_q[k+1];
          history_q[k+1] = tmp;
        end
      end
    end
    for (int k = 0; k + 1 < HISTORY_DEPTH; k++) begin
      if (history_q[k] != '0 && (history_q[k+1] - history_q[k]) < limit_q) begin
        return history_q[k];
      end
    end
    return history_q[HISTORY_DEPTH-1];
  endfunction

  task automatic advance_meter(input cpm_cmd_e cmd, input logic ovf, input logic cap_edge,
                               input logic [CAP_W-1:0] cnt, output meter_beat_t res);
    res = '0;
    case (cmd)
      CMD_TIMER: begin
        if (!done_q) begin
          if (ovf && armed_q) begin
            if (ovf_cnt_q == OVF_MAX) begin
              done_q = 1'b1;
              capture_q = '0;
            end else begin
              ovf_cnt_q = ovf_cnt_q + 1'b1;
            end
          end
          if (cap_edge) begin
            if (armed_q) begin
              capture_q = cnt;
              done_q = 1'b1;
            end else begin
              res.restart = 1'b1;
              ovf_cnt_q = '0;
              capture_q = '0;
              armed_q = 1'b1;
            end
          end
        end
      end
      CMD_POLL: begin
        if (done_q) begin
          slot_q = (slot_q + 1) % HISTORY_DEPTH;
          history_q[slot_q] = {ovf_cnt_q, capture_q};
          last_period_q = {ovf_cnt_q, capture_q};
          done_q = 1'b0;
          armed_q = 1'b0;
          ovf_cnt_q = '0;
          res.ready = 1'b1;
        end
      end
      CMD_SELECT: res.selected = pick_steady_period();
      default: ;
    endcase
    res.period = last_period_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    meter_beat_t want, got;
    if (!rst_ni) begin
      limit_q = LIMIT_RESET;
      done_q = 1'b0;
      armed_q = 1'b0;
      ovf_cnt_q = '0;
      capture_q = '0;
      slot_q = 0;
      last_period_q = '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) history_q[k] = '0;
      meter_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.restart  = m_axis_tdata[0];
        got.ready    = m_axis_tdata[1];
        got.period   = m_axis_tdata[23:2];
        got.selected = m_axis_tdata[45:24];
        if (meter_results_q.size() == 0) begin
          report_mismatch("unexpected output beat", m_axis_tdata, 0);
        end else begin
          want = meter_results_q.pop_front();
          if (got.restart != want.restart)
            report_mismatch("restart_timer", got.restart, want.restart);
          if (got.ready != want.ready)
            report_mismatch("sample_ready", got.ready, want.ready);
          if (got.period != want.period)
            report_mismatch("period_value", got.period, want.period);
          if (got.selected != want.selected)
            report_mismatch("selected_value", got.selected, want.selected);
          if (m_axis_tdata[47:46] != 2'b00)
            report_mismatch("tdata padding", m_axis_tdata[47:46], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_meter(cpm_cmd_e'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[1],
                      s_axis_tdata[17:2], want);
        meter_results_q.push_back(want);
      end
      pending_o <= meter_results_q.size();
    end
  end

endmodule

@@ verif/capture_period_meter_with_history_tb.sv @@
// Testbench top for capture_period_meter_with_history: drives directed and random beats
// of timer events, polls and selects, varies the tolerance, and reports the verdict.
// Depends on cpm_pkg, the block and capture_period_meter_with_history_chk.
module capture_period_meter_with_history_tb import cpm_pkg::*;;

  localparam int HIST_D     = 4;
  localparam int SETTLE     = 12;
  localparam int LONG_HOLD  = 400;
  localparam int MAX_CYCLES = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = CMD_NONE;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic [VAL_W-1:0] cfg_wdata_i = '0;

  int fail_cnt;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int beats_sent = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  logic hold_kick = 1'b0;
  logic hold_used = 1'b0;
  logic [CAP_W-1:0] near_count = '0;

  always #5 clk_i = ~clk_i;

  capture_period_meter_with_history #(.HISTORY_DEPTH(HIST_D)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  capture_period_meter_with_history_chk #(.HISTORY_DEPTH(HIST_D)) i_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i,
    .errors_o(fail_cnt), .pending_o(pending)
  );

  // Receiver: random back-pressure, plus one long hold-off when kicked.
  always @(posedge clk_i) begin
    if (hold_kick && !hold_used) begin
      hold_left = LONG_HOLD;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("capture_period_meter_with_history_tb failed");
      $finish;
    end
  end

  task automatic send_beat(input cpm_cmd_e cmd, input logic ovf, input logic cap_edge,
                           input logic [CAP_W-1:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, cnt, cap_edge, ovf};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd != CMD_NONE) beats_sent++;
  endtask

  // Drop valid, wait for every result, then let a select finish its pass.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [VAL_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [CAP_W-1:0] any_count();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return CAP_W'($urandom_range(65535));
  endfunction

  // One arm / overflow / capture / poll / select sequence with random content.
  task automatic measure_once();
    int r;
    int n_ovf;
    logic [CAP_W-1:0] stop_cnt;
    send_beat(CMD_TIMER, 1'($urandom_range(1)), 1'b1, any_count());
    r = $urandom_range(99);
    if (r < 65)      n_ovf = $urandom_range(3);
    else if (r < 85) n_ovf = $urandom_range(60, 66);
    else             n_ovf = $urandom_range(4, 59);
    for (int i = 0; i < n_ovf; i++) begin
      if ($urandom_range(99) < 10) send_beat(CMD_TIMER, 1'b0, 1'b0, any_count());
      send_beat(CMD_TIMER, 1'b1, 1'b0, any_count());
    end
    if ($urandom_range(99) < 88) begin
      // half the stops land near a common count so that history entries cluster
      stop_cnt = ($urandom_range(1)) ? near_count + CAP_W'($urandom_range(700)) : any_count();
      send_beat(CMD_TIMER, ($urandom_range(99) < 20), 1'b1, stop_cnt);
    end
    if ($urandom_range(99) < 20)
      send_beat(CMD_TIMER, 1'($urandom_range(1)), 1'($urandom_range(1)), any_count());
    if ($urandom_range(99) < 92) send_beat(CMD_POLL, 1'($urandom_range(1)), 1'b0, any_count());
    if ($urandom_range(99) < 15) send_beat(CMD_POLL, 1'b0, 1'($urandom_range(1)), any_count());
    if ($urandom_range(99) < 30) send_beat(CMD_SELECT, 1'($urandom_range(1)),
                                           1'($urandom_range(1)), any_count());
  endtask

  task automatic random_phase(input int budget);
    int stop_at;
    stop_at = beats_sent + budget;
    near_count = CAP_W'($urandom_range(60000));
    while (beats_sent < stop_at) begin
      if ($urandom_range(99) < 12)
        send_beat(cpm_cmd_e'($urandom_range(3)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), any_count());
      else
        measure_once();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, idle poll, unused code, stray overflow
    send_beat(CMD_SELECT, 1'b0, 1'b0, '0);
    send_beat(CMD_POLL, 1'b0, 1'b0, '0);
    send_beat(CMD_NONE, 1'b1, 1'b1, '1);
    send_beat(CMD_TIMER, 1'b1, 1'b0, '1);
    // arm, count, overflow and edge together, edge while done, poll
    send_beat(CMD_TIMER, 1'b0, 1'b1, '1);
    send_beat(CMD_TIMER, 1'b1, 1'b0, 16'h0001);
    send_beat(CMD_TIMER, 1'b0, 1'b0, '0);
    send_beat(CMD_TIMER, 1'b1, 1'b1, '1);
    send_beat(CMD_TIMER, 1'b1, 1'b1, 16'h5555);
    send_beat(CMD_POLL, 1'b0, 1'b0, '0);
    send_beat(CMD_POLL, 1'b0, 1'b0, '0);
    // zero-length period, then two close periods
    send_beat(CMD_TIMER, 1'b0, 1'b1, '0);
    send_beat(CMD_TIMER, 1'b0, 1'b1, '0);
    send_beat(CMD_POLL, 1'b0, 1'b0, '0);
    send_beat(CMD_TIMER, 1'b0, 1'b1, 16'hAAAA);
    send_beat(CMD_TIMER, 1'b0, 1'b1, 16'h1234);
    send_beat(CMD_POLL, 1'b0, 1'b0, '0);
    send_beat(CMD_TIMER, 1'b0, 1'b1, '0);
    send_beat(CMD_TIMER, 1'b0, 1'b1, 16'h1240);
    send_beat(CMD_POLL, 1'b0, 1'b0, '0);
    send_beat(CMD_SELECT, 1'b0, 1'b0, '0);
    send_beat(CMD_NONE, 1'b0, 1'b0, '0);

    write_limit('0);
    tx_idle_pct = 32;
    rx_idle_pct = 61;
    random_phase(485);

    write_limit('1);
    tx_idle_pct = 61;
    rx_idle_pct = 32;
    random_phase(485);

    write_limit(VAL_W'($urandom_range(1, 2000)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_kick = 1'b1;
    random_phase(485);

    write_limit(VAL_W'($urandom_range(300000)));
    random_phase(485);

    drain_results();
    if (fail_cnt == 0 && pending == 0) begin
      $display("capture_period_meter_with_history_tb passed");
    end else begin
      $display("capture_period_meter_with_history_tb failed");
    end
    $finish;
  end

endmodule

@@ capture_period_meter_with_history.f @@
rtl/cpm_pkg.sv
rtl/cpm_outq.sv
rtl/cpm_ctrl.sv
rtl/cpm_dp.sv
rtl/capture_period_meter_with_history.sv
verif/capture_period_meter_with_history_chk.sv
verif/capture_period_meter_with_history_tb.sv
